// ===== design/mhpq_pkg.sv =====
// shared constants for the min-heap priority queue
package mhpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = CNT_W + 1;
    localparam int KEY_W     = 32;
    localparam int ENTRIES_W = 7;

    // result word: popped_key, was_empty, overflow, min_after, entries
    localparam int RES_BITS   = KEY_W + 1 + 1 + KEY_W + ENTRIES_W;
    localparam int RES_DATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic signed [KEY_W-1:0] KEY_NONE = -32'sd1;

    typedef logic signed [KEY_W-1:0] key_t;

endpackage

// ===== design/mhpq_ram.sv =====
// generic ram, one write port and two registered read ports
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== design/min_heap_priority_queue_unit.sv =====
// min-heap priority queue: push or pop one key per request, one result each
//
//   channel | ports                        | contents
//   --------+------------------------------+---------------------------------
//   input   | s_tvalid s_tready s_tdata    | tdata key_in, tuser kind
//           | s_tuser                      |
//   result  | m_tvalid m_tready m_tdata    | popped_key, flags, min, entries
//
// one request at a time; comparators and a two-read-port key ram walk
// the tree, a read state and a compare state per level moved. push: the
// key sifts up from the new leaf toward the root; pop: the last entry is
// loaded and sifts down from the root; a dropped push or an empty pop
// goes straight to the result.
// synchronous active-low reset empties the heap; ram contents are not cleared.
// a stalled result holds in the output register while the next request runs.
module min_heap_priority_queue_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mhpq_pkg::KEY_W-1:0]        s_tdata,  // [31:0] key_in
    input  logic [0:0]                        s_tuser,  // [0] kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] popped_key, [32] was_empty, [33] overflow, [65:34] min_after,
    // [72:66] entries, rest zero
    output logic [mhpq_pkg::RES_DATA_W-1:0]   m_tdata
);
    import mhpq_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UP_RD  = 3'd1;
    localparam logic [2:0] ST_UP_CMP = 3'd2;
    localparam logic [2:0] ST_POP_RD = 3'd3;
    localparam logic [2:0] ST_POP_LD = 3'd4;
    localparam logic [2:0] ST_DN_RD  = 3'd5;
    localparam logic [2:0] ST_DN_CMP = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    key_t              key_reg, key_next;
    key_t              popped_reg, popped_next;
    logic              empty_reg, empty_next;
    logic              over_reg, over_next;
    key_t              root_reg;
    logic              m_tvalid_reg;
    logic [RES_DATA_W-1:0] m_tdata_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    key_t              wr_data;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [KEY_W-1:0]  rd_data_a, rd_data_b;
    key_t              left_key, right_key, best_key;

    logic [IDX_W-1:0]  left_idx, right_idx;
    logic [ADDR_W-1:0] parent_idx;
    logic              left_lt, right_lt, right_ok, req_accept, res_load;
    key_t              min_after;

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_keys (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign req_accept = s_tvalid && s_tready;
    assign res_load   = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    assign left_idx   = IDX_W'({pos_reg, 1'b1});
    assign right_idx  = IDX_W'({pos_reg, 1'b0}) + IDX_W'(2);
    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_key   = key_t'(rd_data_a);
    assign right_key  = key_t'(rd_data_b);
    assign right_ok   = right_idx < IDX_W'(count_reg);
    // moving key sits in key_reg; the hole at pos_reg holds it logically
    assign left_lt    = left_key < key_reg;
    assign best_key   = left_lt ? left_key : key_reg;
    assign right_lt   = right_ok && (right_key < best_key);
    assign min_after  = (count_reg != '0) ? root_reg : KEY_NONE;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        popped_next = popped_reg;
        empty_next  = empty_reg;
        over_next   = over_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = key_reg;
        rd_addr_a   = parent_idx;
        rd_addr_b   = right_idx[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (req_accept) begin
                    popped_next = KEY_NONE;
                    empty_next  = 1'b0;
                    over_next   = 1'b0;
                    if (s_tuser[0] == KIND_PUSH) begin
                        if (count_reg >= CNT_W'(CAPACITY)) begin
                            over_next  = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            key_next   = key_t'(s_tdata);
                            pos_next   = count_reg[ADDR_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                            state_next = ST_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            empty_next = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            popped_next = root_reg;
                            count_next  = count_reg - CNT_W'(1);
                            state_next  = ST_POP_RD;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                wr_en = 1'b1;
                if (left_key > key_reg) begin
                    // parent moves down into the hole
                    wr_data    = left_key;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_POP_RD: begin
                rd_addr_a  = count_reg[ADDR_W-1:0];
                state_next = ST_POP_LD;
            end
            ST_POP_LD: begin
                key_next = left_key;
                pos_next = '0;
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DN_RD;
                end
            end
            ST_DN_RD: begin
                rd_addr_a = left_idx[ADDR_W-1:0];
                if (left_idx >= IDX_W'(count_reg)) begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                wr_en = 1'b1;
                priority if (right_lt) begin
                    wr_data    = right_key;
                    pos_next   = right_idx[ADDR_W-1:0];
                    state_next = ST_DN_RD;
                end else if (left_lt) begin
                    wr_data    = left_key;
                    pos_next   = left_idx[ADDR_W-1:0];
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (res_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        popped_reg <= popped_next;
        empty_reg  <= empty_next;
        over_reg   <= over_next;
        // every root write passes here, so the minimum is kept at hand
        if (wr_en && (wr_addr == '0)) begin
            root_reg <= wr_data;
        end
        if (res_load) begin
            m_tdata_reg <= RES_DATA_W'({ENTRIES_W'(count_reg), min_after,
                                        over_reg, empty_reg, popped_reg});
        end
    end

    // heap never holds more than its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // an accepted push that fits grows the heap by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (req_accept && (s_tuser[0] == KIND_PUSH) && (count_reg < CNT_W'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the heap");

    // a result never flags both empty pop and dropped push
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[KEY_W] && m_tdata[KEY_W+1]))
        else $error("both result flags set");

    // an empty heap reports no minimum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2*KEY_W+2 +: ENTRIES_W] == '0))
        |-> (m_tdata[KEY_W+2 +: KEY_W] == KEY_NONE))
        else $error("empty heap reports a minimum");

endmodule
